### sv/ssrp_pkg.sv
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared constants, types and helpers for the servo status reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrp_pkg;

    // frame buffer depth and the index width it needs
    localparam int FRAME_BYTES_MAX = 20;
    localparam int BUF_IDX_W       = $clog2(FRAME_BYTES_MAX);

    // longest frame the mask can select (status + 17 field bytes + checksum)
    localparam int FRAME_LEN_MAX = 19;

    // result codes
    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_REPLY_ERR = 2'd1;
    localparam logic [1:0] RES_CMD_ERR   = 2'd2;
    localparam logic [1:0] RES_UNUSED    = 2'd3;

    // status bit that flags a command checksum error
    localparam int CMD_ERR_BIT = 1;

    // configuration register indexes
    localparam logic REG_STATUS_ITEMS = 1'b0;

    // byte count of each optional field, mask bit 0 first
    localparam logic [2:0] FIELD_SIZE [8] = '{3'd4, 3'd1, 3'd2, 3'd1,
                                              3'd4, 3'd2, 3'd2, 3'd1};

    typedef logic [FRAME_BYTES_MAX-1:0][7:0] t_frame;

    // frame length for a field mask: status, present fields, checksum
    function automatic logic [4:0] frame_length(input logic [7:0] mask);
        logic [4:0] n;
        n = 5'd2;
        for (int b = 0; b < 8; b++) begin
            if (mask[b]) begin
                n = n + {2'b00, FIELD_SIZE[b]};
            end
        end
        return n;
    endfunction

    // buffer byte with out-of-range reads giving zero
    function automatic logic [7:0] buf_at(input t_frame f, input logic [5:0] i);
        logic [7:0] v;
        v = 8'h00;
        if (i < 6'(FRAME_BYTES_MAX)) begin
            v = f[i[BUF_IDX_W-1:0]];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/servo_status_reply_parser.sv
// ----------------------------------------------------------------------------
// servo_status_reply_parser
// Collects servo reply bytes into frames, checks the additive checksum and
// keeps the last good copy of every status field.
// ----------------------------------------------------------------------------
// One reply byte is taken per cycle unless a checksum byte is held back. A byte
// passes through an input register and is handled in the single processing
// stage against the frame state. The checksum byte of a frame yields one
// result word through the input register and the result register; the result
// register holds it until taken, and other bytes keep flowing meanwhile, so
// only a second checksum byte waits behind an untaken result. The result shows
// the stored fields after the frame. status_items sets the frame layout; the
// user is to rewrite it only while no byte is in flight, which the block itself
// does not enforce. The layout in force at each byte sets the frame end.
`default_nettype none

module servo_status_reply_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_restart,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [1:0]         o_result_code,
    output logic      [7:0]         o_status_byte,
    output logic signed [31:0]      o_position,
    output logic      [7:0]         o_ad_value,
    output logic signed [15:0]      o_velocity,
    output logic      [7:0]         o_aux_status,
    output logic      [31:0]        o_home_position,
    output logic      [7:0]         o_module_type,
    output logic      [7:0]         o_module_version,
    output logic signed [15:0]      o_position_error,
    output logic      [7:0]         o_path_points
);

    // configuration register
    logic [7:0] r_status_items;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;

    // frame state
    logic [4:0]       r_byte_index, n_byte_index;
    logic [7:0]       r_sum, n_sum;
    ssrp_pkg::t_frame r_buf;

    // held fields, also the result payload
    logic [7:0]  r_held_status;
    logic [31:0] r_held_position;
    logic [7:0]  r_held_ad;
    logic [15:0] r_held_velocity;
    logic [7:0]  r_held_aux;
    logic [31:0] r_held_home;
    logic [7:0]  r_held_type;
    logic [7:0]  r_held_version;
    logic [15:0] r_held_perror;
    logic [7:0]  r_held_npoints;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_code, n_out_code;

    // processing stage signals
    logic [4:0] idx_eff;
    logic [7:0] sum_eff;
    logic [4:0] frame_len;
    logic       is_last;
    logic       advance;
    logic       take_byte;
    logic       finish;
    logic       sum_ok;
    logic       cmd_err;
    logic [4:0] off [8];
    logic [5:0] o_pos, o_ad, o_vel, o_aux, o_home, o_id, o_perr, o_np;

    // apb register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ssrp_pkg::REG_STATUS_ITEMS) ? {24'h0, r_status_items}
                                                             : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_items <= 8'h00;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == ssrp_pkg::REG_STATUS_ITEMS)) begin
            r_status_items <= pwdata[7:0];
        end
    end

    // frame position of this byte and end-of-frame test
    always_comb begin
        idx_eff   = r_in_restart ? 5'd0 : r_byte_index;
        sum_eff   = r_in_restart ? 8'd0 : r_sum;
        frame_len = ssrp_pkg::frame_length(r_status_items);
        is_last   = ({1'b0, idx_eff} + 6'd1) >= {1'b0, frame_len};
    end

    // stage advances unless a checksum byte meets an untaken result
    assign advance    = r_in_valid && (!is_last || !r_out_valid || i_out_ready);
    assign take_byte  = advance && !is_last;
    assign finish     = advance && is_last;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_rx_byte;
            r_in_restart <= i_restart;
        end
    end

    // field offsets within the frame for the current mask
    always_comb begin
        off[0] = 5'd1;
        for (int b = 0; b < 7; b++) begin
            off[b+1] = off[b] + (r_status_items[b] ? {2'b00, ssrp_pkg::FIELD_SIZE[b]}
                                                   : 5'd0);
        end
        o_pos  = {1'b0, off[0]};
        o_ad   = {1'b0, off[1]};
        o_vel  = {1'b0, off[2]};
        o_aux  = {1'b0, off[3]};
        o_home = {1'b0, off[4]};
        o_id   = {1'b0, off[5]};
        o_perr = {1'b0, off[6]};
        o_np   = {1'b0, off[7]};
    end

    // checksum and command error checks
    assign sum_ok  = (sum_eff == r_in_byte);
    assign cmd_err = r_buf[0][ssrp_pkg::CMD_ERR_BIT];

    // next frame state
    always_comb begin
        n_byte_index = r_byte_index;
        n_sum        = r_sum;
        if (take_byte) begin
            n_byte_index = idx_eff + 5'd1;
            n_sum        = sum_eff + r_in_byte;
        end else if (finish) begin
            n_byte_index = 5'd0;
            n_sum        = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 5'd0;
            r_sum        <= 8'd0;
        end else begin
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
        end
    end

    // frame buffer write
    always_ff @(posedge i_clk) begin
        if (take_byte && ({1'b0, idx_eff} < 6'(ssrp_pkg::FRAME_BYTES_MAX))) begin
            r_buf[idx_eff[ssrp_pkg::BUF_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // result code
    always_comb begin
        if (!sum_ok) begin
            n_out_code = ssrp_pkg::RES_REPLY_ERR;
        end else if (cmd_err) begin
            n_out_code = ssrp_pkg::RES_CMD_ERR;
        end else begin
            n_out_code = ssrp_pkg::RES_OK;
        end
    end

    // result valid
    always_comb begin
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_code <= n_out_code;
        end
    end

    // held field update on a good frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_status   <= 8'h00;
            r_held_position <= 32'h0;
            r_held_ad       <= 8'h00;
            r_held_velocity <= 16'h0;
            r_held_aux      <= 8'h00;
            r_held_home     <= 32'h0;
            r_held_type     <= 8'h00;
            r_held_version  <= 8'h00;
            r_held_perror   <= 16'h0;
            r_held_npoints  <= 8'h00;
        end else if (finish && sum_ok) begin
            r_held_status <= ssrp_pkg::buf_at(r_buf, 6'd0);
            if (!cmd_err) begin
                if (r_status_items[0]) begin
                    r_held_position <= {ssrp_pkg::buf_at(r_buf, o_pos + 6'd3),
                                        ssrp_pkg::buf_at(r_buf, o_pos + 6'd2),
                                        ssrp_pkg::buf_at(r_buf, o_pos + 6'd1),
                                        ssrp_pkg::buf_at(r_buf, o_pos)};
                end
                if (r_status_items[1]) begin
                    r_held_ad <= ssrp_pkg::buf_at(r_buf, o_ad);
                end
                if (r_status_items[2]) begin
                    r_held_velocity <= {ssrp_pkg::buf_at(r_buf, o_vel + 6'd1),
                                        ssrp_pkg::buf_at(r_buf, o_vel)};
                end
                if (r_status_items[3]) begin
                    r_held_aux <= ssrp_pkg::buf_at(r_buf, o_aux);
                end
                if (r_status_items[4]) begin
                    r_held_home <= {ssrp_pkg::buf_at(r_buf, o_home + 6'd3),
                                    ssrp_pkg::buf_at(r_buf, o_home + 6'd2),
                                    ssrp_pkg::buf_at(r_buf, o_home + 6'd1),
                                    ssrp_pkg::buf_at(r_buf, o_home)};
                end
                if (r_status_items[5]) begin
                    r_held_type    <= ssrp_pkg::buf_at(r_buf, o_id);
                    r_held_version <= ssrp_pkg::buf_at(r_buf, o_id + 6'd1);
                end
                if (r_status_items[6]) begin
                    r_held_perror <= {ssrp_pkg::buf_at(r_buf, o_perr + 6'd1),
                                      ssrp_pkg::buf_at(r_buf, o_perr)};
                end
                if (r_status_items[7]) begin
                    r_held_npoints <= ssrp_pkg::buf_at(r_buf, o_np);
                end
            end
        end
    end

    // result outputs
    assign o_out_valid      = r_out_valid;
    assign o_result_code    = r_out_code;
    assign o_status_byte    = r_held_status;
    assign o_position       = $signed(r_held_position);
    assign o_ad_value       = r_held_ad;
    assign o_velocity       = $signed(r_held_velocity);
    assign o_aux_status     = r_held_aux;
    assign o_home_position  = r_held_home;
    assign o_module_type    = r_held_type;
    assign o_module_version = r_held_version;
    assign o_position_error = $signed(r_held_perror);
    assign o_path_points    = r_held_npoints;

`ifndef ASSERT_OFF
    // a waiting result keeps its fields
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_held_status) && $stable(r_out_code)
                                          && $stable(r_held_position)))
        else $error("waiting result changed");

    // only defined result codes leave the block
    a_code_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code != ssrp_pkg::RES_UNUSED))
        else $error("undefined result code");

    // frame index never reaches the longest frame length
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index < 5'(ssrp_pkg::FRAME_LEN_MAX))
        else $error("frame index out of range");

    // a finished frame clears the frame state
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> ((r_byte_index == 5'd0) && (r_sum == 8'd0) && r_out_valid))
        else $error("frame state not cleared after checksum byte");
`endif

endmodule

`default_nettype wire

### test/tb_servo_status_reply_parser.sv
// ----------------------------------------------------------------------------
// tb_servo_status_reply_parser
// Self-checking bench for the servo status reply parser. Reply frames are
// built from the active field mask and sent one byte word at a time. The
// frames are good, carry a bad checksum, flag a command error, are cut short
// by a restart, or are pure noise. A parallel model of the parser predicts
// every result word, and each result is checked field by field. The mask is
// rewritten between phases, sometimes while a frame is half received.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_servo_status_reply_parser;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_BYTES   = 105;
    localparam int LAST_BYTES    = 80;
    localparam int RUN_LIMIT     = 2_000_000;

    typedef enum {FILL_RANDOM, FILL_ONES} t_fill_kind;

    typedef struct packed {
        logic [1:0]  code;
        logic [7:0]  status;
        logic [31:0] position;
        logic [7:0]  ad;
        logic [15:0] velocity;
        logic [7:0]  aux;
        logic [31:0] home;
        logic [7:0]  mod_type;
        logic [7:0]  mod_version;
        logic [15:0] perror;
        logic [7:0]  npoints;
    } t_status_reply;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_result_code;
    logic [7:0]  o_status_byte;
    logic signed [31:0] o_position;
    logic [7:0]  o_ad_value;
    logic signed [15:0] o_velocity;
    logic [7:0]  o_aux_status;
    logic [31:0] o_home_position;
    logic [7:0]  o_module_type;
    logic [7:0]  o_module_version;
    logic signed [15:0] o_position_error;
    logic [7:0]  o_path_points;

    // parser model state
    logic [7:0]    items_mask = '0;
    logic [4:0]    rx_index = '0;
    logic [7:0]    rx_sum = '0;
    logic [7:0]    rx_frame [ssrp_pkg::FRAME_BYTES_MAX] = '{default: 8'h00};
    t_status_reply held = '0;

    t_status_reply pending_replies [$];
    int            fail_count = 0;
    int            bytes_sent = 0;
    bit            idles_on = 1'b1;
    int            stall_left = 0;

    servo_status_reply_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_code    (o_result_code),
        .o_status_byte    (o_status_byte),
        .o_position       (o_position),
        .o_ad_value       (o_ad_value),
        .o_velocity       (o_velocity),
        .o_aux_status     (o_aux_status),
        .o_home_position  (o_home_position),
        .o_module_type    (o_module_type),
        .o_module_version (o_module_version),
        .o_position_error (o_position_error),
        .o_path_points    (o_path_points)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // frame length: status, selected fields, checksum
    function automatic int frame_bytes(input logic [7:0] mask);
        return 2 + 4 * mask[0] + mask[1] + 2 * mask[2] + mask[3]
                 + 4 * mask[4] + 2 * mask[5] + 2 * mask[6] + mask[7];
    endfunction

    function automatic logic [7:0] frame_byte(input int i);
        return (i < ssrp_pkg::FRAME_BYTES_MAX) ? rx_frame[i] : 8'h00;
    endfunction

    // little-endian field of n bytes starting at byte i
    function automatic logic [31:0] frame_le(input int i, input int n);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < n; k++) begin
            v[8*k +: 8] = frame_byte(i + k);
        end
        return v;
    endfunction

    // advance the parser model by one accepted byte word
    function automatic void parse_reply_byte(input logic [7:0] b, input logic rs);
        int p;
        if (rs) begin
            rx_index = '0;
            rx_sum   = '0;
        end
        if (int'(rx_index) + 1 < frame_bytes(items_mask)) begin
            if (rx_index < ssrp_pkg::FRAME_BYTES_MAX) begin
                rx_frame[rx_index] = b;
            end
            rx_sum   = rx_sum + b;
            rx_index = rx_index + 5'd1;
            return;
        end
        // checksum byte closes the frame
        if (rx_sum != b) begin
            held.code = ssrp_pkg::RES_REPLY_ERR;
        end else begin
            held.status = frame_byte(0);
            if (held.status[ssrp_pkg::CMD_ERR_BIT]) begin
                held.code = ssrp_pkg::RES_CMD_ERR;
            end else begin
                held.code = ssrp_pkg::RES_OK;
                p = 1;
                if (items_mask[0]) begin
                    held.position = frame_le(p, 4);
                    p += 4;
                end
                if (items_mask[1]) begin
                    held.ad = frame_byte(p);
                    p += 1;
                end
                if (items_mask[2]) begin
                    held.velocity = 16'(frame_le(p, 2));
                    p += 2;
                end
                if (items_mask[3]) begin
                    held.aux = frame_byte(p);
                    p += 1;
                end
                if (items_mask[4]) begin
                    held.home = frame_le(p, 4);
                    p += 4;
                end
                if (items_mask[5]) begin
                    held.mod_type    = frame_byte(p);
                    held.mod_version = frame_byte(p + 1);
                    p += 2;
                end
                if (items_mask[6]) begin
                    held.perror = 16'(frame_le(p, 2));
                    p += 2;
                end
                if (items_mask[7]) begin
                    held.npoints = frame_byte(p);
                end
            end
        end
        rx_index = '0;
        rx_sum   = '0;
        pending_replies.push_back(held);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS) begin
                $display("mismatch %s: expected %h got %h", name, want, got);
            end
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : reply_monitor
        t_status_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("unexpected result word, code %0d", o_result_code);
                end
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("result_code", {30'h0, want.code}, {30'h0, o_result_code});
                check_field("status_byte", {24'h0, want.status}, {24'h0, o_status_byte});
                check_field("position", want.position, $unsigned(o_position));
                check_field("ad_value", {24'h0, want.ad}, {24'h0, o_ad_value});
                check_field("velocity", {16'h0, want.velocity}, {16'h0, o_velocity});
                check_field("aux_status", {24'h0, want.aux}, {24'h0, o_aux_status});
                check_field("home_position", want.home, o_home_position);
                check_field("module_type", {24'h0, want.mod_type},
                            {24'h0, o_module_type});
                check_field("module_version", {24'h0, want.mod_version},
                            {24'h0, o_module_version});
                check_field("position_error", {16'h0, want.perror},
                            {16'h0, o_position_error});
                check_field("path_points", {24'h0, want.npoints}, {24'h0, o_path_points});
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idles_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // send one byte word, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic rs);
        if (idles_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        i_restart  <= rs;
        do @(posedge i_clk); while (!o_in_ready);
        parse_reply_byte(b, rs);
        bytes_sent++;
    endtask

    // let every pending result drain and the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_items_mask(input logic [7:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ssrp_pkg::REG_STATUS_ITEMS, 2'b00};
        pwdata  <= {24'h0, mask};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        items_mask = mask;
    endtask

    function automatic logic [7:0] random_status();
        logic [7:0] s;
        s = 8'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            s[ssrp_pkg::CMD_ERR_BIT] = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [7:0] fill_value(input t_fill_kind fill);
        return (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    endfunction

    // field bytes up to the checksum, then the checksum itself
    task automatic finish_frame(input t_fill_kind fill, input bit bad_sum);
        logic [7:0] flip;
        while (int'(rx_index) + 1 < frame_bytes(items_mask)) begin
            send_byte(fill_value(fill), 1'b0);
        end
        flip = bad_sum ? 8'($urandom_range(1, 255)) : 8'h00;
        send_byte(rx_sum ^ flip, 1'b0);
    endtask

    // whole frame; restart is forced when the parser is mid-frame
    task automatic send_frame(input logic [7:0] status, input t_fill_kind fill,
                              input bit bad_sum);
        send_byte(status, (rx_index != 0) ? 1'b1 : 1'($urandom_range(0, 1)));
        finish_frame(fill, bad_sum);
    endtask

    // status-only frames: ok, command error, bad checksum, restart
    task automatic test_short_frames();
        write_items_mask(8'h00);
        send_frame(8'h00, FILL_RANDOM, 1'b0);
        send_frame(8'hFF, FILL_RANDOM, 1'b0);
        send_frame(8'h5C, FILL_RANDOM, 1'b1);
        send_byte(8'hA0, 1'b1);
        send_frame(8'h01, FILL_RANDOM, 1'b0);
    endtask

    // every field present, all ones
    task automatic test_full_frame();
        wait_idle();
        write_items_mask(8'hFF);
        send_frame(8'hFD, FILL_ONES, 1'b0);
    endtask

    // layout shrinks, then grows, while a frame is partly received
    task automatic test_mask_change_mid_frame();
        send_byte(random_status(), 1'b1);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        wait_idle();
        write_items_mask(8'h00);
        finish_frame(FILL_RANDOM, 1'b0);
        send_byte(random_status(), 1'b1);
        wait_idle();
        write_items_mask(8'h21);
        finish_frame(FILL_RANDOM, 1'b0);
    endtask

    task automatic random_traffic();
        int n;
        case ($urandom_range(0, 9))
            0: begin
                // noise
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
            1: begin
                // frame cut short, the next one restarts
                n = $urandom_range(0, frame_bytes(items_mask) - 2);
                send_byte(random_status(), 1'b1);
                repeat (n) send_byte(8'($urandom), 1'b0);
            end
            2: send_frame(random_status(), FILL_RANDOM, 1'b1);
            3: send_frame(random_status(), FILL_ONES, 1'b0);
            default: send_frame(random_status(), FILL_RANDOM, 1'b0);
        endcase
    endtask

    // phases over several layouts, some ending mid-frame
    task automatic test_random_traffic();
        logic [7:0] fixed_masks [4] = '{8'h01, 8'h80, 8'h00, 8'hFF};
        logic [7:0] mask;
        int         target;
        int         n;
        for (int ph = 0; ph < 7; ph++) begin
            mask = (ph < 4) ? fixed_masks[ph] : 8'($urandom);
            wait_idle();
            write_items_mask(mask);
            idles_on = (ph % 3) != 2;
            if (rx_index != 0) begin
                finish_frame(FILL_RANDOM, 1'($urandom_range(0, 1)));
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                random_traffic();
            end
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(0, frame_bytes(items_mask) - 2);
                send_byte(random_status(), 1'b1);
                repeat (n) send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back();
        int target;
        wait_idle();
        idles_on = 1'b0;
        write_items_mask(8'($urandom));
        target = bytes_sent + LAST_BYTES;
        while (bytes_sent < target) begin
            send_frame(random_status(), FILL_RANDOM, 1'($urandom_range(0, 7) == 0));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_frames();
        test_full_frame();
        test_mask_change_mid_frame();
        test_random_traffic();
        test_back_to_back();
        wait_idle();
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### servo_status_reply_parser.f
sv/ssrp_pkg.sv
sv/servo_status_reply_parser.sv
test/tb_servo_status_reply_parser.sv
